// ===== design/lkvc_pkg.sv =====
// Shared constants and types for the LRU key-value cache.
package lkvc_pkg;

  // Default geometry
  localparam int ENTRIES_DEF     = 16;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Capacity register
  localparam int                  CAP_WIDTH = 5;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

  // Access kinds
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

endpackage

// ===== design/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
//
// Usage:
//   Request channel: drive operation_i (get or put), key_i and write_value_i
//   and raise start_i; the beat is taken at the rising edge where start_i is
//   high and busy_o is low. busy_o stays low, so a request can enter every
//   cycle.
//   Result channel: done_o is high for exactly one cycle with found_o and
//   read_value_o. The receiver cannot stall; each result must be taken in
//   that cycle.
//   Capacity: cfg_we_i writes cfg_wdata_i into the capacity register; 0
//   acts as 1 and values above ENTRIES act as ENTRIES. Write it only while
//   no request is in flight.
// Timing:
//   The request register loads at the accepting edge and the result register
//   after it; done_o, found_o and read_value_o come straight from the result
//   register. Throughput is one request per cycle, set by the single pass
//   of parallel key compare and rank update between the two registers.
// Reset:
//   All entries become invalid, occupancy clears and capacity returns to 16.
module lru_key_value_cache #(
  parameter int ENTRIES     = lkvc_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                operation_i,
  input  logic signed [KEY_WIDTH-1:0]         key_i,
  input  logic signed [VALUE_WIDTH-1:0]       write_value_i,
  input  logic                                cfg_we_i,
  input  logic        [lkvc_pkg::CAP_WIDTH-1:0] cfg_wdata_i,
  output logic                                done_o,
  output logic                                found_o,
  output logic signed [VALUE_WIDTH-1:0]       read_value_o
);
  import lkvc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_WIDTH) ? OCC_W : CAP_WIDTH;

  // Capacity register
  logic [CAP_WIDTH-1:0] capacity_q;

  // Request register
  logic                   req_valid_q;
  op_e                    req_op_q;
  logic [KEY_WIDTH-1:0]   req_key_q;
  logic [VALUE_WIDTH-1:0] req_value_q;

  // Entry state
  logic [ENTRIES-1:0]     valid_q, valid_d;
  logic [IDX_W-1:0]       rank_q [ENTRIES];
  logic [IDX_W-1:0]       rank_d [ENTRIES];
  logic [KEY_WIDTH-1:0]   key_q [ENTRIES];
  logic [VALUE_WIDTH-1:0] value_q [ENTRIES];
  logic [OCC_W-1:0]       occ_q, occ_d;

  // Result register
  logic                   done_q;
  logic                   found_q;
  logic [VALUE_WIDTH-1:0] read_value_q;

  // Lookup and replacement
  logic [ENTRIES-1:0] hit_vec;
  logic               hit_any;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   victim_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   target_idx;
  logic [IDX_W-1:0]   oldest_rank;
  logic [IDX_W-1:0]   rank_limit;
  logic [CMP_W-1:0]   eff_cap;
  logic               is_put;
  logic               evict;
  logic               insert;
  logic               touch;

  assign busy_o = 1'b0;
  assign is_put = (req_op_q == OP_PUT);

  // Clamp capacity into 1..ENTRIES
  always_comb begin
    if (capacity_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity_q) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity_q);
    end
  end

  // Compare the key against every entry in parallel
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == req_key_q);
    end
  end

  assign hit_any     = |hit_vec;
  assign oldest_rank = IDX_W'(occ_q - OCC_W'(1));

  // Pick hit, victim and first free slot
  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (valid_q[i] && (rank_q[i] == oldest_rank)) begin
        victim_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign evict      = (CMP_W'(occ_q) >= eff_cap);
  assign insert     = req_valid_q && is_put && !hit_any;
  assign touch      = req_valid_q && (hit_any || is_put);
  assign target_idx = hit_any ? hit_idx : (evict ? victim_idx : free_idx);
  assign rank_limit = rank_q[hit_idx];

  // Promote the touched entry and age the ones above it
  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (touch) begin
        if (IDX_W'(i) == target_idx) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (!hit_any || (rank_q[i] < rank_limit))) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end
    end
    if (insert) begin
      valid_d[target_idx] = 1'b1;
      if (!evict) begin
        occ_d = occ_q + OCC_W'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CAP_RESET;
      req_valid_q <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      done_q      <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      req_valid_q <= start_i && !busy_o;
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      done_q      <= req_valid_q;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Capture the request beat
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_op_q    <= op_e'(operation_i);
      req_key_q   <= key_i;
      req_value_q <= write_value_i;
    end
  end

  // Write key and value into the touched entry
  always_ff @(posedge clk_i) begin
    if (req_valid_q && is_put) begin
      value_q[target_idx] <= req_value_q;
      if (!hit_any) begin
        key_q[target_idx] <= req_key_q;
      end
    end
  end

  // Register the result
  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      found_q      <= hit_any;
      read_value_q <= (hit_any && !is_put) ? value_q[hit_idx] : '0;
    end
  end

  assign done_o       = done_q;
  assign found_o      = found_q;
  assign read_value_o = read_value_q;

endmodule

// ===== design/lkvc_checker.sv =====
// Port-level checker for the LRU key-value cache, bound to the top level.
module lkvc_checker #(
  parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          operation_i,
  input logic signed [KEY_WIDTH-1:0]   key_i,
  input logic signed [VALUE_WIDTH-1:0] write_value_i,
  input logic                          done_o,
  input logic                          found_o,
  input logic signed [VALUE_WIDTH-1:0] read_value_o
);
  import lkvc_pkg::*;

  logic acc;
  assign acc = start_i && !busy_o && rst_ni;

  // Every taken beat yields a result on done_o
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##2 done_o)
    else $error("result missing after accepted request");

  // No result without a request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |-> ##2 !done_o)
    else $error("result without accepted request");

  // A miss returns zero data
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (read_value_o == '0))
    else $error("nonzero read value on miss");

  // A get right after a put of the same key hits with the new value
  a_put_then_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (operation_i == OP_PUT)) ##1
    (acc && (operation_i == OP_GET) && (key_i == $past(key_i)))
    |-> ##2 (found_o && (read_value_o == $past(write_value_i, 3))))
    else $error("get after put of same key did not return stored value");

endmodule

bind lru_key_value_cache lkvc_checker #(
  .KEY_WIDTH  (KEY_WIDTH),
  .VALUE_WIDTH(VALUE_WIDTH)
) u_lkvc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .operation_i  (operation_i),
  .key_i        (key_i),
  .write_value_i(write_value_i),
  .done_o       (done_o),
  .found_o      (found_o),
  .read_value_o (read_value_o)
);
